// ===== hdl/tst_pkg.sv =====
// ----------------------------------------------------------------------------
// Task slot table package
// Shared constants, operation and status codes, and the control and status
// words that pass between the sequencer and the scan unit.
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int SLOTS_DEF  = 256;
  localparam int OWNERS_DEF = 8;

  localparam int FUNC_W  = 2;
  localparam int OWNER_W = 3;
  localparam int KIND_W  = 8;
  localparam int COORD_W = 18;
  localparam int SLOT_W  = 9;

  // Wide enough for a slot index or a count at the largest table size.
  localparam int IDX_W = 11;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_FIND   = 2'd1,
    FUNC_NEXT   = 2'd2,
    FUNC_REMOVE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_MISS      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_BAD_OWNER = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SCAN_FIND = 2'd0,
    SCAN_NEXT = 2'd1,
    SCAN_FREE = 2'd2
  } scan_mode_e;

  typedef struct packed {
    logic              go;
    scan_mode_e        mode;
    logic [IDX_W-1:0]  first;
    logic [IDX_W-1:0]  limit;
  } scan_ctl_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic              done;
    logic              hit;
    logic [IDX_W-1:0]  found;
  } scan_st_t;

endpackage

// ===== hdl/task_slot_table.sv =====
// ----------------------------------------------------------------------------
// Task slot table
// Per-owner tables of task slots with append, find, next-live and
// swap-remove, kept in one shared RAM and walked by a slot scan unit.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                         words
//  command   in         start high while busy is low      func, owner, kind,
//                                                          coords, slot index
//  result    out        result_valid_o high for one cycle status, found slot,
//                                                          live count
//
// A command is taken on the edge where start is high and busy is low, and its
// result is shown in the cycle after the last working cycle. An insert that
// appends, any command for an owner out of range, an invalid remove and a
// find or next over an empty range finish on the accepting edge itself, so the
// result appears in the next cycle. A remove reads the top slot, copies it
// into the removed slot and clears the top. Find and next scan from their
// start slot to the mark; an insert into a full table scans it for the
// lowest empty slot and fills it. The scan reads one slot per cycle through
// the single RAM port. Reset clears the marks and counts at once; the slot RAM
// needs no clearing pass, since only slots below the mark are ever read. The
// receiver cannot stall, so a result never waits or blocks the next command.
// ----------------------------------------------------------------------------
module task_slot_table #(
  parameter int SLOTS  = tst_pkg::SLOTS_DEF,
  parameter int OWNERS = tst_pkg::OWNERS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic        [tst_pkg::FUNC_W-1:0]   func_i,
  input  logic        [tst_pkg::OWNER_W-1:0]  owner_i,
  input  logic        [tst_pkg::KIND_W-1:0]   task_kind_i,
  input  logic        [tst_pkg::COORD_W-1:0]  coords_i,
  input  logic signed [tst_pkg::SLOT_W-1:0]   slot_index_i,
  output logic                                result_valid_o,
  output logic        [1:0]                   status_o,
  output logic signed [tst_pkg::SLOT_W-1:0]   found_slot_o,
  output logic        [tst_pkg::SLOT_W-1:0]   live_count_o
);

  // Slot index, count and owner widths follow the table size.
  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int OW    = (OWNERS > 1) ? $clog2(OWNERS) : 1;
  localparam int DEPTH = OWNERS * SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = tst_pkg::KIND_W + tst_pkg::COORD_W;

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_FILL   = 5'b00100,
    S_RM_CP  = 5'b01000,
    S_RM_CLR = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Command word held for the multi-cycle operations.
  logic [tst_pkg::FUNC_W-1:0]  cmd_func_q, cmd_func_d;
  logic [OW-1:0]               cmd_owner_q, cmd_owner_d;
  logic [tst_pkg::KIND_W-1:0]  cmd_kind_q, cmd_kind_d;
  logic [tst_pkg::COORD_W-1:0] cmd_coords_q, cmd_coords_d;
  logic [IW-1:0]               cmd_idx_q, cmd_idx_d;
  logic [IW-1:0]               cmd_top_q, cmd_top_d;

  // Per-owner high-water marks and live counts, cleared by reset.
  logic [CW-1:0] mark_q  [OWNERS];
  logic [CW-1:0] count_q [OWNERS];

  logic          tab_we;
  logic [OW-1:0] tab_owner;
  logic [CW-1:0] tab_mark;
  logic [CW-1:0] tab_count;

  // Result register.
  logic                              res_valid_q, res_valid_d;
  tst_pkg::status_e                  res_status_q, res_status_d;
  logic signed [tst_pkg::SLOT_W-1:0] res_found_q, res_found_d;
  logic [tst_pkg::SLOT_W-1:0]        res_count_q, res_count_d;

  // Slot RAM port.
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_addr;
  logic [DW-1:0] ram_wdata;
  logic [DW-1:0] ram_rdata;

  tst_pkg::scan_ctl_t scan_ctl;
  tst_pkg::scan_st_t  scan_st;

  // Decode of the incoming command against its owner's table.
  logic          owner_ok;
  logic [OW-1:0] own_in;
  logic [CW-1:0] mark_in;
  logic [CW-1:0] count_in;
  logic [9:0]    next_start;
  logic          next_ok;
  logic          rm_ok;
  logic [CW-1:0] mark_cmd;
  logic [CW-1:0] count_cmd;

  // Flat RAM address of one owner's slot.
  function automatic logic [AW-1:0] slot_addr(input logic [OW-1:0] own,
                                               input logic [IW-1:0] slot);
    slot_addr = AW'(int'(own) * SLOTS + int'(slot));
  endfunction

  function automatic logic [CW-1:0] count_up(input logic [CW-1:0] cnt);
    count_up = (int'(cnt) >= SLOTS) ? cnt : cnt + CW'(1);
  endfunction

  function automatic logic [CW-1:0] count_down(input logic [CW-1:0] cnt);
    count_down = (cnt == '0) ? cnt : cnt - CW'(1);
  endfunction

  assign owner_ok = int'(owner_i) < OWNERS;
  assign own_in   = OW'(owner_i);
  assign mark_in  = owner_ok ? mark_q[own_in] : '0;
  assign count_in = owner_ok ? count_q[own_in] : '0;

  // Next searches from the slot after the given index; a negative index means
  // from the beginning of the table.
  assign next_start = slot_index_i[8] ? 10'd0 : ({2'b00, slot_index_i[7:0]} + 10'd1);
  assign next_ok    = int'(next_start) < int'(mark_in);
  assign rm_ok      = !slot_index_i[8] && (int'(slot_index_i[7:0]) < int'(mark_in));

  assign mark_cmd  = mark_q[cmd_owner_q];
  assign count_cmd = count_q[cmd_owner_q];

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    cmd_func_d   = cmd_func_q;
    cmd_owner_d  = cmd_owner_q;
    cmd_kind_d   = cmd_kind_q;
    cmd_coords_d = cmd_coords_q;
    cmd_idx_d    = cmd_idx_q;
    cmd_top_d    = cmd_top_q;

    tab_we    = 1'b0;
    tab_owner = cmd_owner_q;
    tab_mark  = mark_cmd;
    tab_count = count_cmd;

    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_count_d  = res_count_q;

    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = slot_addr(cmd_owner_q, cmd_idx_q);
    ram_wdata = {cmd_kind_q, cmd_coords_q};

    scan_ctl.go    = 1'b0;
    scan_ctl.mode  = tst_pkg::SCAN_FIND;
    scan_ctl.first = '0;
    scan_ctl.limit = tst_pkg::IDX_W'(mark_in);

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_func_d   = func_i;
          cmd_owner_d  = own_in;
          cmd_kind_d   = task_kind_i;
          cmd_coords_d = coords_i;
          cmd_idx_d    = IW'(slot_index_i[7:0]);
          cmd_top_d    = IW'(mark_in - CW'(1));
          res_found_d  = '1;
          res_count_d  = tst_pkg::SLOT_W'(count_in);
          tab_owner    = own_in;
          tab_mark     = mark_in;
          tab_count    = count_in;
          if (!owner_ok) begin
            res_valid_d  = 1'b1;
            res_status_d = tst_pkg::ST_BAD_OWNER;
            res_count_d  = '0;
          end else begin
            unique case (func_i)
              tst_pkg::FUNC_INSERT: begin
                if (int'(mark_in) < SLOTS) begin
                  // Room above the mark: append in the accepting cycle.
                  ram_we       = 1'b1;
                  ram_addr     = slot_addr(own_in, IW'(mark_in));
                  ram_wdata    = {task_kind_i, coords_i};
                  tab_we       = 1'b1;
                  tab_mark     = mark_in + CW'(1);
                  tab_count    = count_up(count_in);
                  res_valid_d  = 1'b1;
                  res_status_d = tst_pkg::ST_DONE;
                  res_count_d  = tst_pkg::SLOT_W'(count_up(count_in));
                end else begin
                  // Table filled to the top: look for the lowest empty slot.
                  scan_ctl.go    = 1'b1;
                  scan_ctl.mode  = tst_pkg::SCAN_FREE;
                  scan_ctl.limit = tst_pkg::IDX_W'(SLOTS);
                  state_d        = S_SCAN;
                end
              end
              tst_pkg::FUNC_FIND: begin
                if (mark_in != '0) begin
                  scan_ctl.go   = 1'b1;
                  scan_ctl.mode = tst_pkg::SCAN_FIND;
                  state_d       = S_SCAN;
                end else begin
                  res_valid_d  = 1'b1;
                  res_status_d = tst_pkg::ST_MISS;
                end
              end
              tst_pkg::FUNC_NEXT: begin
                if (next_ok) begin
                  scan_ctl.go    = 1'b1;
                  scan_ctl.mode  = tst_pkg::SCAN_NEXT;
                  scan_ctl.first = tst_pkg::IDX_W'(next_start);
                  state_d        = S_SCAN;
                end else begin
                  res_valid_d  = 1'b1;
                  res_status_d = tst_pkg::ST_MISS;
                end
              end
              tst_pkg::FUNC_REMOVE: begin
                if (rm_ok) begin
                  // Fetch the top slot; it moves into the removed one.
                  ram_re   = 1'b1;
                  ram_addr = slot_addr(own_in, IW'(mark_in - CW'(1)));
                  state_d  = S_RM_CP;
                end else begin
                  res_valid_d  = 1'b1;
                  res_status_d = tst_pkg::ST_BAD_INDEX;
                end
              end
              default: begin
                res_valid_d  = 1'b1;
                res_status_d = tst_pkg::ST_MISS;
              end
            endcase
          end
        end
      end

      S_SCAN: begin
        ram_re   = scan_st.rd_en;
        ram_addr = slot_addr(cmd_owner_q, IW'(scan_st.rd_idx));
        if (scan_st.done) begin
          res_count_d = tst_pkg::SLOT_W'(count_cmd);
          if (cmd_func_q == tst_pkg::FUNC_INSERT) begin
            if (scan_st.hit) begin
              cmd_idx_d = IW'(scan_st.found);
              state_d   = S_FILL;
            end else begin
              res_valid_d  = 1'b1;
              res_status_d = tst_pkg::ST_MISS;
              res_found_d  = '1;
              state_d      = S_IDLE;
            end
          end else begin
            res_valid_d = 1'b1;
            if (scan_st.hit) begin
              res_status_d = tst_pkg::ST_DONE;
              res_found_d  = tst_pkg::SLOT_W'(scan_st.found);
            end else begin
              res_status_d = tst_pkg::ST_MISS;
              res_found_d  = '1;
            end
            state_d = S_IDLE;
          end
        end
      end

      S_FILL: begin
        ram_we       = 1'b1;
        tab_we       = 1'b1;
        tab_count    = count_up(count_cmd);
        res_valid_d  = 1'b1;
        res_status_d = tst_pkg::ST_DONE;
        res_found_d  = '1;
        res_count_d  = tst_pkg::SLOT_W'(count_up(count_cmd));
        state_d      = S_IDLE;
      end

      S_RM_CP: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        state_d   = S_RM_CLR;
      end

      S_RM_CLR: begin
        // Clearing the top after the copy also covers removal of the top slot.
        ram_we       = 1'b1;
        ram_addr     = slot_addr(cmd_owner_q, cmd_top_q);
        ram_wdata    = '0;
        tab_we       = 1'b1;
        tab_mark     = CW'(cmd_top_q);
        tab_count    = count_down(count_cmd);
        res_valid_d  = 1'b1;
        res_status_d = tst_pkg::ST_DONE;
        res_found_d  = '1;
        res_count_d  = tst_pkg::SLOT_W'(count_down(count_cmd));
        state_d      = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      for (int o = 0; o < OWNERS; o++) begin
        mark_q[o]  <= '0;
        count_q[o] <= '0;
      end
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (tab_we) begin
        mark_q[tab_owner]  <= tab_mark;
        count_q[tab_owner] <= tab_count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_func_q   <= cmd_func_d;
    cmd_owner_q  <= cmd_owner_d;
    cmd_kind_q   <= cmd_kind_d;
    cmd_coords_q <= cmd_coords_d;
    cmd_idx_q    <= cmd_idx_d;
    cmd_top_q    <= cmd_top_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_count_q  <= res_count_d;
  end

  tst_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  tst_scan #(
    .SLOTS (SLOTS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (scan_ctl),
    .key_i    (cmd_coords_q),
    .kind_i   (ram_rdata[DW-1:tst_pkg::COORD_W]),
    .coords_i (ram_rdata[tst_pkg::COORD_W-1:0]),
    .st_o     (scan_st)
  );

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign found_slot_o   = res_found_q;
  assign live_count_o   = res_count_q;

  // The scan unit only ever finishes while the sequencer waits on it.
  a_scan_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_st.done |-> (state_q == S_SCAN))
    else $error("scan finished outside the scan state");

  // Every copy of the top slot is followed by clearing the top.
  a_copy_then_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RM_CP) |=> (state_q == S_RM_CLR))
    else $error("remove copy not followed by top clear");

  // Filling a free slot only happens on a table whose mark is at the top.
  a_fill_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (int'(mark_cmd) == SLOTS))
    else $error("free-slot fill on a table below its top");

  // The closing step of a remove always produces a result word.
  a_remove_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RM_CLR) |=> result_valid_o)
    else $error("remove finished without a result");

endmodule

// ===== hdl/tst_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, read data registered.
// ----------------------------------------------------------------------------
module tst_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tst_scan.sv =====
// ----------------------------------------------------------------------------
// Task slot table scan unit
// Walks a range of slots, one read issued per cycle, and compares each
// returned word against the search condition until a hit or the range ends.
// ----------------------------------------------------------------------------
module tst_scan #(
  parameter int SLOTS = tst_pkg::SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tst_pkg::scan_ctl_t           ctl_i,
  input  logic [tst_pkg::COORD_W-1:0]  key_i,
  input  logic [tst_pkg::KIND_W-1:0]   kind_i,
  input  logic [tst_pkg::COORD_W-1:0]  coords_i,
  output tst_pkg::scan_st_t            st_o
);

  localparam int CW = $clog2(SLOTS + 1);

  logic                active_q, active_d;
  logic                pend_q, pend_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       pidx_q, pidx_d;
  logic [CW-1:0]       limit_q, limit_d;
  tst_pkg::scan_mode_e mode_q, mode_d;

  logic issue;
  logic hit;
  logic done;

  always_comb begin
    hit = 1'b0;
    unique case (mode_q)
      tst_pkg::SCAN_FIND: hit = (kind_i != '0) && (coords_i == key_i);
      tst_pkg::SCAN_NEXT: hit = (kind_i != '0);
      tst_pkg::SCAN_FREE: hit = (kind_i == '0);
      default:            hit = 1'b0;
    endcase
    hit = hit && pend_q;
  end

  assign issue = active_q && (idx_q < limit_q);
  assign done  = active_q && (hit || (!issue && !pend_q));

  always_comb begin
    active_d = active_q;
    pend_d   = pend_q;
    idx_d    = idx_q;
    pidx_d   = pidx_q;
    limit_d  = limit_q;
    mode_d   = mode_q;
    if (ctl_i.go) begin
      active_d = 1'b1;
      pend_d   = 1'b0;
      idx_d    = CW'(ctl_i.first);
      limit_d  = CW'(ctl_i.limit);
      mode_d   = ctl_i.mode;
    end else if (done) begin
      active_d = 1'b0;
      pend_d   = 1'b0;
    end else if (active_q) begin
      pend_d = issue;
      pidx_d = idx_q;
      if (issue) begin
        idx_d = idx_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pend_q   <= 1'b0;
      mode_q   <= tst_pkg::SCAN_FIND;
    end else begin
      active_q <= active_d;
      pend_q   <= pend_d;
      mode_q   <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pidx_q  <= pidx_d;
    limit_q <= limit_d;
  end

  assign st_o.rd_en  = issue;
  assign st_o.rd_idx = tst_pkg::IDX_W'(idx_q);
  assign st_o.done   = done;
  assign st_o.hit    = hit;
  assign st_o.found  = tst_pkg::IDX_W'(pidx_q);

  // A new scan always reads at least one slot, so two completions never abut.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done)
    else $error("scan completed on two cycles in a row");

endmodule

// ===== tb/sv/slot_table_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Task slot table checker
// Watches the command and result channels of the task slot table. It keeps
// its own copy of every owner's slots, mark and count, works out the reply
// that each accepted command word must give, and compares each result word
// with the oldest reply still due.
// ----------------------------------------------------------------------------
module slot_table_checker
  import tst_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEF,
  parameter int OWNERS = OWNERS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic        [FUNC_W-1:0]  func_i,
  input  logic        [OWNER_W-1:0] owner_i,
  input  logic        [KIND_W-1:0]  task_kind_i,
  input  logic        [COORD_W-1:0] coords_i,
  input  logic signed [SLOT_W-1:0]  slot_index_i,
  input  logic                      result_valid_i,
  input  logic        [1:0]         status_i,
  input  logic signed [SLOT_W-1:0]  found_slot_i,
  input  logic        [SLOT_W-1:0]  live_count_i,
  output int                        errors_o,
  output int                        pending_o
);

  localparam logic [SLOT_W-1:0] NO_SLOT = '1;

  typedef struct {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [SLOT_W-1:0]  count;
  } slot_reply_t;

  // Shadow copy of the slot tables, one block of SLOTS entries per owner.
  bit [KIND_W-1:0]  kind_tab  [OWNERS*SLOTS];
  bit [COORD_W-1:0] coord_tab [OWNERS*SLOTS];
  int               mark_tab  [OWNERS];
  int               count_tab [OWNERS];

  slot_reply_t replies_due [$];
  int          failures = 0;

  // Carries out one command on the shadow tables and returns its reply.
  function automatic slot_reply_t apply_command(func_e op, int owner,
                                                logic [KIND_W-1:0] kind,
                                                logic [COORD_W-1:0] crd, int idx);
    slot_reply_t r;
    int base;
    int mark;
    int pick;
    int first;
    r.status = ST_DONE;
    r.slot   = NO_SLOT;
    r.count  = '0;
    if (owner >= OWNERS) begin
      r.status = ST_BAD_OWNER;
      return r;
    end
    base = owner * SLOTS;
    mark = mark_tab[owner];
    pick = -1;
    case (op)
      FUNC_INSERT: begin
        // Append while there is room above the mark, else reuse the lowest
        // empty slot anywhere in the table.
        if (mark < SLOTS) begin
          pick = mark;
          mark_tab[owner] = mark + 1;
        end else begin
          for (int i = 0; i < SLOTS && pick < 0; i++)
            if (kind_tab[base+i] == '0) pick = i;
        end
        if (pick < 0) begin
          r.status = ST_MISS;
        end else begin
          kind_tab[base+pick]  = kind;
          coord_tab[base+pick] = crd;
          if (count_tab[owner] < SLOTS) count_tab[owner]++;
        end
      end
      FUNC_FIND, FUNC_NEXT: begin
        // Next starts just after a non-negative index; find always starts at
        // slot zero. Only live slots below the mark are considered.
        first = (op == FUNC_NEXT && idx >= 0) ? idx + 1 : 0;
        for (int i = first; i < mark && pick < 0; i++)
          if (kind_tab[base+i] != '0 && (op == FUNC_NEXT || coord_tab[base+i] == crd))
            pick = i;
        if (pick < 0) r.status = ST_MISS;
        else r.slot = SLOT_W'(pick);
      end
      default: begin
        if (idx < 0 || idx >= mark) begin
          r.status = ST_BAD_INDEX;
        end else begin
          // The top slot moves into the hole and is then cleared.
          mark = mark - 1;
          mark_tab[owner]      = mark;
          kind_tab[base+idx]   = kind_tab[base+mark];
          coord_tab[base+idx]  = coord_tab[base+mark];
          kind_tab[base+mark]  = '0;
          coord_tab[base+mark] = '0;
          if (count_tab[owner] > 0) count_tab[owner]--;
        end
      end
    endcase
    r.count = SLOT_W'(count_tab[owner]);
    return r;
  endfunction

  // Compares one result word with the oldest reply due.
  task automatic check_reply();
    slot_reply_t want;
    if (replies_due.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("%0t: result word with none due: status %0d slot %0d count %0d",
                 $realtime, status_i, found_slot_i, live_count_i);
    end else begin
      want = replies_due.pop_front();
      if (status_i !== want.status || found_slot_i !== want.slot ||
          live_count_i !== want.count) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch: expected status %0d slot %0d count %0d, got %0d %0d %0d",
                   $realtime, want.status, $signed(want.slot), want.count,
                   status_i, found_slot_i, live_count_i);
      end
    end
  endtask

  // Outputs are updated with nonblocking assignments so that the stimulus
  // side sees the values from before the edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replies_due.delete();
      for (int o = 0; o < OWNERS; o++) begin
        mark_tab[o]  = 0;
        count_tab[o] = 0;
      end
      pending_o <= 0;
      errors_o  <= failures;
    end else begin
      // A result can never belong to a command taken on the same edge, so the
      // result is checked before the new command is added.
      if (result_valid_i) check_reply();
      if (start_i && !busy_i)
        replies_due.push_back(apply_command(func_e'(func_i), int'(owner_i), task_kind_i,
                                            coords_i, int'(slot_index_i)));
      pending_o <= replies_due.size();
      errors_o  <= failures;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Task slot table testbench
// Drives command words into the task slot table: a short directed run over
// empty tables, skipped empty slots, search starts and invalid removes, then
// random bursts that fill whole tables, mix operations on one owner, or send
// plain noise. A separate checker predicts and compares every result word;
// this module only makes stimulus, watches for a hang and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import tst_pkg::*;

  localparam int SLOTS  = SLOTS_DEF;
  localparam int OWNERS = OWNERS_DEF;
  // Number of random command words after the directed part.
  localparam int ITEMS  = 2000;
  // Idle cycles allowed without any word moving. The slowest correct wait is a
  // full-table scan or the final settling period.
  localparam int HANG_LIMIT = 4000;
  // Cycles left after the last reply, long enough for any stray late result.
  localparam int SETTLE = 300;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      start        = 1'b0;
  logic        [FUNC_W-1:0]  func_i       = FUNC_INSERT;
  logic        [OWNER_W-1:0] owner_i      = '0;
  logic        [KIND_W-1:0]  task_kind_i  = '0;
  logic        [COORD_W-1:0] coords_i     = '0;
  logic signed [SLOT_W-1:0]  slot_index_i = '0;
  logic                      busy;
  logic                      result_valid_o;
  logic        [1:0]         status_o;
  logic signed [SLOT_W-1:0]  found_slot_o;
  logic        [SLOT_W-1:0]  live_count_o;
  int                        errors;
  int                        pending;

  // Mark of each owner as the stimulus side sees it, used only to aim slot
  // indexes and to know when a table has filled.
  int               fill [OWNERS];
  // A small set of coordinates, so that finds often hit.
  logic [COORD_W-1:0] coord_pool [8];
  // When set, the sender issues words back to back.
  bit               calm;
  int               sent;

  always #10 clk_i = ~clk_i;

  task_slot_table #(
    .SLOTS  (SLOTS),
    .OWNERS (OWNERS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .owner_i        (owner_i),
    .task_kind_i    (task_kind_i),
    .coords_i       (coords_i),
    .slot_index_i   (slot_index_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .found_slot_o   (found_slot_o),
    .live_count_o   (live_count_o)
  );

  slot_table_checker #(
    .SLOTS  (SLOTS),
    .OWNERS (OWNERS)
  ) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .func_i         (func_i),
    .owner_i        (owner_i),
    .task_kind_i    (task_kind_i),
    .coords_i       (coords_i),
    .slot_index_i   (slot_index_i),
    .result_valid_i (result_valid_o),
    .status_i       (status_o),
    .found_slot_i   (found_slot_o),
    .live_count_i   (live_count_o),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // Mostly short gaps, now and then a long one, none at all in calm bursts.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic int pool_coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, (1 << COORD_W) - 1);
    return coord_pool[$urandom_range(0, 7)];
  endfunction

  // Any value of the 9-bit signed index, negative ones included.
  function automatic int any_index();
    return int'($urandom_range(0, 511)) - 256;
  endfunction

  // Presents one command word, holds it until it is taken, then leaves a gap.
  // Start is only lowered when a gap follows, so it is never dropped and
  // raised again within one edge.
  task automatic send_word(func_e op, int owner, int kind, int crd, int idx);
    int gap;
    start        <= 1'b1;
    func_i       <= op;
    owner_i      <= owner[OWNER_W-1:0];
    task_kind_i  <= kind[KIND_W-1:0];
    coords_i     <= crd[COORD_W-1:0];
    slot_index_i <= idx[SLOT_W-1:0];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
    if (op == FUNC_INSERT && fill[owner] < SLOTS) fill[owner]++;
    if (op == FUNC_REMOVE && idx >= 0 && idx < fill[owner]) fill[owner]--;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the sender off until every reply due has arrived. The first edge
  // lets the checker count the word just taken.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Watchdog: ends the run if no word moves on either channel for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < HANG_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || result_valid_o) idle = 0;
      else idle++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int roll;
    int owner;
    int len;
    int fills;
    int op;
    int idx;
    int kind;
    sent  = 0;
    fills = 0;
    calm  = 1'b0;
    for (int o = 0; o < OWNERS; o++) fill[o] = 0;
    for (int k = 0; k < 8; k++) coord_pool[k] = $urandom_range(0, (1 << COORD_W) - 1);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Searches and removes on an empty table come first.
    send_word(FUNC_FIND,   3, 0,    0,       0);
    send_word(FUNC_NEXT,   3, 0,    0,       -1);
    send_word(FUNC_REMOVE, 3, 0,    0,       0);
    // Owner 0 gets four slots; slot 1 holds kind 0 and must be skipped.
    send_word(FUNC_INSERT, 0, 255,  'h3FFFF, 0);
    send_word(FUNC_INSERT, 0, 0,    0,       0);
    send_word(FUNC_INSERT, 0, 1,    0,       0);
    send_word(FUNC_INSERT, 0, 'h80, 'h2AAAA, 0);
    send_word(FUNC_FIND,   0, 0,    0,       0);
    send_word(FUNC_FIND,   0, 0,    'h3FFFF, 0);
    send_word(FUNC_FIND,   0, 0,    'h15555, 0);
    // Next from the start, from the most negative index, and from past the
    // end of the used range.
    send_word(FUNC_NEXT,   0, 0,    0,       -1);
    send_word(FUNC_NEXT,   0, 0,    0,       -256);
    send_word(FUNC_NEXT,   0, 0,    0,       0);
    send_word(FUNC_NEXT,   0, 0,    0,       3);
    send_word(FUNC_NEXT,   0, 0,    0,       255);
    // Removes with an index below zero, at the mark and far above it.
    send_word(FUNC_REMOVE, 0, 0,    0,       -1);
    send_word(FUNC_REMOVE, 0, 0,    0,       4);
    send_word(FUNC_REMOVE, 0, 0,    0,       255);
    // A swap from the top into slot 0, then removal of the top slot itself.
    send_word(FUNC_REMOVE, 0, 0,    0,       0);
    send_word(FUNC_FIND,   0, 0,    'h2AAAA, 0);
    send_word(FUNC_REMOVE, 0, 0,    0,       2);
    // The highest owner, emptied down to a count of zero and then once more.
    send_word(FUNC_INSERT, 7, 'h7F, 'h15555, 0);
    send_word(FUNC_REMOVE, 7, 0,    0,       0);
    send_word(FUNC_REMOVE, 7, 0,    0,       0);
    drain();

    sent = 0;
    while (sent < ITEMS) begin
      calm = ($urandom_range(0, 9) < 3);
      roll = $urandom_range(0, 99);
      if (fills < 2 && (roll < 8 || sent > 600 * (fills + 1))) begin
        // Fill one table to the top with a few empty kinds scattered in it,
        // then keep inserting so that the empty slots are reused and the
        // table finally reports full. Full-length scans follow.
        fills++;
        owner = $urandom_range(0, OWNERS - 1);
        while (fill[owner] < SLOTS)
          send_word(FUNC_INSERT, owner, ($urandom_range(0, 31) == 0) ? 0 :
                    $urandom_range(1, 255), pool_coord(), any_index());
        repeat (24)
          send_word(FUNC_INSERT, owner, $urandom_range(1, 255), pool_coord(), any_index());
        repeat (8)
          send_word($urandom_range(0, 1) ? FUNC_FIND : FUNC_NEXT, owner,
                    $urandom_range(0, 255), pool_coord(), any_index());
      end else if (roll < 18) begin
        // Noise: every field random.
        repeat ($urandom_range(5, 15))
          send_word(func_e'($urandom_range(0, 3)), $urandom_range(0, OWNERS - 1),
                    $urandom_range(0, 255), $urandom_range(0, (1 << COORD_W) - 1),
                    any_index());
      end else begin
        // A run of mixed operations aimed mostly at one owner, with indexes
        // chosen from the used range so that removes mostly succeed.
        owner = $urandom_range(0, OWNERS - 1);
        len   = $urandom_range(8, 40);
        repeat (len) begin
          if ($urandom_range(0, 7) == 0) owner = $urandom_range(0, OWNERS - 1);
          roll = $urandom_range(0, 99);
          kind = $urandom_range(0, 255);
          if (roll < 35) begin
            op   = FUNC_INSERT;
            kind = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255);
            idx  = any_index();
          end else if (roll < 55) begin
            op  = FUNC_FIND;
            idx = any_index();
          end else if (roll < 75) begin
            op   = FUNC_NEXT;
            roll = $urandom_range(0, 9);
            if (roll < 3) idx = -1;
            else if (roll < 4) idx = -int'($urandom_range(1, 256));
            else idx = $urandom_range(0, fill[owner]);
          end else begin
            op = FUNC_REMOVE;
            if (fill[owner] > 0 && $urandom_range(0, 4) != 0)
              idx = $urandom_range(0, fill[owner] - 1);
            else
              idx = any_index();
          end
          send_word(func_e'(op), owner, kind, pool_coord(), idx);
        end
      end
      if ($urandom_range(0, 5) == 0) drain();
    end

    // Wait for the last replies, then give any stray result time to show.
    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tst_pkg.sv
hdl/tst_ram.sv
hdl/tst_scan.sv
hdl/task_slot_table.sv
tb/sv/slot_table_checker.sv
tb/sv/testbench.sv
